@@ hw/rtl/pscf_pkg.sv @@
// ----------------------------------------------------------------------------
// pscf_pkg
// Shared widths and constants for the palette special color finder.
// ----------------------------------------------------------------------------
package pscf_pkg;

	localparam int GUN_BITS    = 6;
	localparam int INDEX_BITS  = 8;
	localparam int BRT_BITS    = 8;
	localparam int SIZE_BITS   = 9;
	localparam int MAX_ENTRIES = 256;

	localparam logic [BRT_BITS-1:0] MEDIUM_LOW  = BRT_BITS'(80);
	localparam logic [BRT_BITS-1:0] MEDIUM_HIGH = BRT_BITS'(150);
	localparam logic [BRT_BITS-1:0] MIN_BRT_RESET = BRT_BITS'(255);

	localparam logic [INDEX_BITS-1:0] DEFAULT_DARK   = INDEX_BITS'(0);
	localparam logic [INDEX_BITS-1:0] DEFAULT_BRIGHT = INDEX_BITS'(15);
	localparam logic [INDEX_BITS-1:0] DEFAULT_MEDIUM = INDEX_BITS'(7);

	// Configuration register indexes.
	localparam logic REG_PALETTE_SIZE = 1'b0;
	localparam logic REG_REAL_PALETTE = 1'b1;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_ENTRIES);
	localparam logic [SIZE_BITS-1:0] SIZE_TWO   = SIZE_BITS'(2);

endpackage

@@ hw/rtl/palette_special_color_finder.sv @@
// ----------------------------------------------------------------------------
// palette_special_color_finder
// Scans palette entries and reports the darkest, brightest and medium entry.
// ----------------------------------------------------------------------------
// The block takes one palette entry per cycle. Each accepted item is held in
// an input register and, in the following cycle, compared against the
// running darkest, brightest and medium records; when the item is the last
// of a scan, the three indices are loaded into the result register, which
// drives the output. The only thing that holds the input back is the single
// result register: if a scan ends while the previous result is still
// stalled, the last item waits in the input register until that result is
// taken.
module palette_special_color_finder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [pscf_pkg::SIZE_BITS-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pscf_pkg::GUN_BITS-1:0]     red,
	input  logic [pscf_pkg::GUN_BITS-1:0]     green,
	input  logic [pscf_pkg::GUN_BITS-1:0]     blue,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pscf_pkg::INDEX_BITS-1:0]   dark_index,
	output logic [pscf_pkg::INDEX_BITS-1:0]   bright_index,
	output logic [pscf_pkg::INDEX_BITS-1:0]   medium_index
);
	import pscf_pkg::*;

	logic [SIZE_BITS-1:0]  palette_size_q;
	logic                  real_palette_q;

	logic                  valid_s1;
	logic [GUN_BITS-1:0]   red_s1, green_s1, blue_s1;

	logic [INDEX_BITS-1:0] entry_count_q;
	logic [BRT_BITS-1:0]   max_brt_q, min_brt_q, best_score_q;
	logic [INDEX_BITS-1:0] dark_q, bright_q, medium_q;

	logic                  out_valid_q;
	logic [INDEX_BITS-1:0] dark_out_q, bright_out_q, medium_out_q;

	logic                  in_accept, out_accept, advance, last_s1, is_medium;
	logic [SIZE_BITS-1:0]  size_eff;
	logic [BRT_BITS-1:0]   brt, score;
	logic [GUN_BITS-1:0]   gun_hi, gun_lo, spread;
	logic [BRT_BITS-1:0]   max_brt_d, min_brt_d, best_score_d;
	logic [INDEX_BITS-1:0] dark_d, bright_d, medium_d;

	always_comb begin
		if (palette_size_q == '0 || palette_size_q > SIZE_RESET) begin
			size_eff = SIZE_RESET;
		end else begin
			size_eff = palette_size_q;
		end
	end

	assign brt = BRT_BITS'(red_s1) + BRT_BITS'(green_s1) + BRT_BITS'(blue_s1);

	always_comb begin
		gun_hi = red_s1;
		gun_lo = red_s1;
		if (green_s1 > gun_hi) gun_hi = green_s1;
		if (green_s1 < gun_lo) gun_lo = green_s1;
		if (blue_s1 > gun_hi) gun_hi = blue_s1;
		if (blue_s1 < gun_lo) gun_lo = blue_s1;
	end

	assign spread    = gun_hi - gun_lo;
	assign score     = brt - BRT_BITS'(spread >> 1);
	assign is_medium = (brt > MEDIUM_LOW) && (brt < MEDIUM_HIGH);
	assign last_s1   = (SIZE_BITS'(entry_count_q) + SIZE_BITS'(1)) >= size_eff;

	// Running records including the entry in the input register.
	always_comb begin
		max_brt_d    = max_brt_q;
		bright_d     = bright_q;
		min_brt_d    = min_brt_q;
		dark_d       = dark_q;
		best_score_d = best_score_q;
		medium_d     = medium_q;
		if (brt > max_brt_q) begin
			max_brt_d = brt;
			bright_d  = entry_count_q;
		end
		if (brt < min_brt_q) begin
			min_brt_d = brt;
			dark_d    = entry_count_q;
		end
		if (is_medium && score > best_score_q) begin
			best_score_d = score;
			medium_d     = entry_count_q;
		end
	end

	assign out_accept = out_valid_q && !out_stall;
	assign advance    = valid_s1 && !(last_s1 && out_valid_q && out_stall);
	assign in_stall   = valid_s1 && !advance;
	assign in_accept  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= SIZE_RESET;
			real_palette_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PALETTE_SIZE: palette_size_q <= cfg_data;
				REG_REAL_PALETTE: real_palette_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			max_brt_q     <= '0;
			min_brt_q     <= MIN_BRT_RESET;
			best_score_q  <= '0;
			dark_q        <= DEFAULT_DARK;
			bright_q      <= DEFAULT_BRIGHT;
			medium_q      <= DEFAULT_MEDIUM;
		end else if (advance) begin
			if (last_s1) begin
				entry_count_q <= '0;
				max_brt_q     <= '0;
				min_brt_q     <= MIN_BRT_RESET;
				best_score_q  <= '0;
				dark_q        <= DEFAULT_DARK;
				bright_q      <= DEFAULT_BRIGHT;
				medium_q      <= DEFAULT_MEDIUM;
			end else begin
				entry_count_q <= entry_count_q + INDEX_BITS'(1);
				max_brt_q     <= max_brt_d;
				min_brt_q     <= min_brt_d;
				best_score_q  <= best_score_d;
				dark_q        <= dark_d;
				bright_q      <= bright_d;
				medium_q      <= medium_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_accept) begin
			out_valid_q <= 1'b0;
		end
	end

	// A two-entry palette always reports 0, 1, 1; otherwise a palette that
	// is not real reports the defaults.
	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			if (size_eff == SIZE_TWO) begin
				dark_out_q   <= INDEX_BITS'(0);
				bright_out_q <= INDEX_BITS'(1);
				medium_out_q <= INDEX_BITS'(1);
			end else if (!real_palette_q) begin
				dark_out_q   <= DEFAULT_DARK;
				bright_out_q <= DEFAULT_BRIGHT;
				medium_out_q <= DEFAULT_MEDIUM;
			end else begin
				dark_out_q   <= dark_d;
				bright_out_q <= bright_d;
				medium_out_q <= medium_d;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign dark_index   = dark_out_q;
	assign bright_index = bright_out_q;
	assign medium_index = medium_out_q;

	// A scan that ends while the previous result is stalled must wait.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid_q && out_stall) |-> in_stall)
		else $error("scan end overran a pending result");

	// Every finished scan starts the next one from entry zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (entry_count_q == '0 && out_valid_q))
		else $error("scan did not restart after its result");

	// A medium score only exists once an entry brighter than the low bound was seen.
	assert property (@(posedge clk) disable iff (!arst_n)
		(best_score_q != '0) |-> (max_brt_q > MEDIUM_LOW))
		else $error("medium score without a matching bright entry");

endmodule
